FILE: hdl/mu8_pkg.sv
// Shared types and byte classification for the modified UTF-8 decoder.
`timescale 1ns / 1ps

package mu8_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;
  localparam int unsigned NeedW = 2;

  typedef enum logic [2:0] {
    BYTE_ASCII,
    BYTE_LEAD2,
    BYTE_LEAD3,
    BYTE_CONT,
    BYTE_INVALID
  } byte_class_t;

  typedef struct packed {
    logic [NeedW-1:0] bytes_still_needed;
    logic [UnitW-1:0] partial_unit;
  } dec_state_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             bad_sequence;
    logic             end_of_string;
  } result_t;

  function automatic byte_class_t classify(input logic [ByteW-1:0] b);
    byte_class_t c;
    unique casez (b)
      8'b0???????: c = BYTE_ASCII;
      8'b10??????: c = BYTE_CONT;
      8'b110?????: c = BYTE_LEAD2;
      8'b1110????: c = BYTE_LEAD3;
      default:     c = BYTE_INVALID;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/mu8_step.sv
// Combinational decode of one byte against the current sequence state.
`timescale 1ns / 1ps

module mu8_step (
  input  logic [mu8_pkg::ByteW-1:0] byte_in,
  input  logic                      last_in,
  input  mu8_pkg::dec_state_t       state,
  output mu8_pkg::dec_state_t       state_next,
  output logic                      has_result,
  output mu8_pkg::result_t          result
);
  import mu8_pkg::*;

  byte_class_t      cls;
  logic             emit;
  logic             bad;
  logic [UnitW-1:0] unit;

  assign cls = classify(byte_in);

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    bad        = 1'b0;
    unit       = '0;

    if (state.bytes_still_needed == '0) begin
      unique case (cls)
        BYTE_ASCII: begin
          unit = {{(UnitW-ByteW){1'b0}}, byte_in};
          emit = 1'b1;
        end
        BYTE_LEAD2: begin
          state_next.partial_unit       = {5'b0, byte_in[4:0], 6'b0};
          state_next.bytes_still_needed = NeedW'(1);
        end
        BYTE_LEAD3: begin
          state_next.partial_unit       = {byte_in[3:0], 12'b0};
          state_next.bytes_still_needed = NeedW'(2);
        end
        default: begin
          bad  = 1'b1;
          emit = 1'b1;
        end
      endcase
    end else if (cls == BYTE_CONT) begin
      if (state.bytes_still_needed >= NeedW'(2)) begin
        // middle byte of a three-byte sequence
        state_next.partial_unit       = state.partial_unit | {4'b0, byte_in[5:0], 6'b0};
        state_next.bytes_still_needed = NeedW'(1);
      end else begin
        unit = state.partial_unit | {10'b0, byte_in[5:0]};
        state_next.partial_unit       = '0;
        state_next.bytes_still_needed = '0;
        emit = 1'b1;
      end
    end else begin
      bad  = 1'b1;
      emit = 1'b1;
    end

    if (bad) begin
      state_next = '0;
    end

    if (last_in) begin
      // unfinished sequence at end of string is an error
      if (!emit) begin
        bad = 1'b1;
      end
      state_next = '0;
    end
  end

  assign has_result           = emit | last_in;
  assign result.code_unit     = bad ? '0 : unit;
  assign result.bad_sequence  = bad;
  assign result.end_of_string = last_in;

endmodule

FILE: hdl/mu8_out_reg.sv
// Output result register with valid/ready handshake.
`timescale 1ns / 1ps

module mu8_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_valid,
  output logic             load_ready,
  input  mu8_pkg::result_t load_data,
  output logic             out_valid,
  input  logic             out_ready,
  output mu8_pkg::result_t out_data
);
  import mu8_pkg::*;

  logic    held_valid;
  result_t held;

  assign load_ready = !held_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load_ready) begin
      held_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      held <= load_data;
    end
  end

  assign out_valid = held_valid;
  assign out_data  = held;

endmodule

FILE: hdl/modified_utf8_to_utf16_decoder.sv
// Top level: modified UTF-8 byte stream in, UTF-16 code units out.
`timescale 1ns / 1ps

//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  input   | in_valid, in_ready  | byte_value[7:0], last_byte
//  output  | out_valid, out_ready| code_unit[15:0], bad_sequence, end_of_string
//
//  One byte per cycle sustained while out_ready stays high; each byte passes
//  through the input register, then is decoded into the result register.
//  A byte that completes nothing (lead or middle continuation, last_byte low)
//  updates the sequence state and produces no output transfer.
//  rst is synchronous: clears both valid flags and the sequence state.
//  When the result register is held by out_ready low, a byte that would emit
//  waits in the input register; in_ready then follows out_ready combinationally.

module modified_utf8_to_utf16_decoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mu8_pkg::ByteW-1:0] byte_value,
  input  logic                      last_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mu8_pkg::UnitW-1:0] code_unit,
  output logic                      bad_sequence,
  output logic                      end_of_string
);
  import mu8_pkg::*;

  // input register
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_last;

  // sequence state
  dec_state_t state;
  dec_state_t state_next;

  logic    has_result;
  result_t result;
  logic    slot_ready;
  logic    advance;
  result_t out_data;

  // the held byte retires once its result (if any) has a place to go
  assign advance  = s1_valid && (!has_result || slot_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= byte_value;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  mu8_step u_step (
    .byte_in    (s1_byte),
    .last_in    (s1_last),
    .state      (state),
    .state_next (state_next),
    .has_result (has_result),
    .result     (result)
  );

  mu8_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_valid && has_result),
    .load_ready (slot_ready),
    .load_data  (result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign code_unit     = out_data.code_unit;
  assign bad_sequence  = out_data.bad_sequence;
  assign end_of_string = out_data.end_of_string;

endmodule
